// File: hw/rtl/rht_pkg.sv
// Shared types and constants for the receipt handle table.
package rht_pkg;

    // Port field widths
    localparam int OPCODE_W = 3;
    localparam int ITEM_W   = 32;
    localparam int RCPT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int FREQ_W   = 5;
    localparam int SIZE_W   = 5;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TAKE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FREQ  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // One result item as handed to the output register
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RCPT_W-1:0]   receipt_out;
        logic [ITEM_W-1:0]   item_out;
        logic                found;
        logic [FREQ_W-1:0]   frequency;
        logic [SIZE_W-1:0]   size;
        logic                empty_res;
    } t_result;

endpackage

// File: hw/rtl/rht_mem.sv
// Synchronous memory: one write port, one read port, registered read data.
module rht_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rht_ctrl.sv
// Sequencer: put, take out with swap, clear and value scans over the two memories.
module rht_ctrl #(
    parameter int CAPACITY = 16,
    parameter int DATA_W   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rht_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [rht_pkg::ITEM_W-1:0]    i_item_value,
    input  logic [rht_pkg::RCPT_W-1:0]    i_receipt_in,
    // Result toward the output register
    input  logic                          i_out_free,
    output logic                          o_res_valid,
    output rht_pkg::t_result              o_res,
    // Shared memory addresses
    output logic [$clog2(CAPACITY)-1:0]   o_raddr,
    output logic [$clog2(CAPACITY)-1:0]   o_waddr,
    // Value memory
    output logic                          o_val_we,
    output logic [DATA_W-1:0]             o_val_wdata,
    input  logic [DATA_W-1:0]             i_val_rdata,
    // Receipt memory
    output logic                          o_hdl_we,
    output logic [$clog2(CAPACITY)-1:0]   o_hdl_wdata,
    input  logic [$clog2(CAPACITY)-1:0]   i_hdl_rdata
);

    import rht_pkg::*;

    localparam int HW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (HW > RCPT_W) ? HW : RCPT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUTRD  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_TKLAST = 3'd3;
    localparam logic [2:0] S_TKFREE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [DATA_W-1:0]   r_val, n_val;
    logic [RCPT_W-1:0]   r_rcpt, n_rcpt;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_hw, n_hw;        // slots that already own a receipt
    logic [HW-1:0]       r_addr, n_addr;    // address read in the previous cycle, during a scan
    logic [HW-1:0]       r_hit, n_hit;
    logic [CW-1:0]       r_freq, n_freq;
    t_result             r_res, n_res;

    logic [CW-1:0] cnt_m1;
    logic [HW-1:0] cnt_addr;
    logic [HW-1:0] last_addr;
    logic          is_last;
    logic          val_match;
    logic          hdl_match;
    logic [CW-1:0] freq_nxt;

    assign cnt_m1    = r_count - CW'(1);
    assign cnt_addr  = r_count[HW-1:0];
    assign last_addr = cnt_m1[HW-1:0];
    assign is_last   = (r_addr == last_addr);
    assign val_match = (i_val_rdata == r_val);
    assign hdl_match = (CMP_W'(i_hdl_rdata) == CMP_W'(r_rcpt));
    assign freq_nxt  = r_freq + CW'(val_match);

    // Next state and memory control
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_rcpt      = r_rcpt;
        n_count     = r_count;
        n_hw        = r_hw;
        n_addr      = r_addr;
        n_hit       = r_hit;
        n_freq      = r_freq;
        n_res       = r_res;
        o_raddr     = r_addr;
        o_waddr     = r_addr;
        o_val_we    = 1'b0;
        o_val_wdata = r_val;
        o_hdl_we    = 1'b0;
        o_hdl_wdata = i_hdl_rdata;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_opcode;
                    n_val   = DATA_W'(i_item_value);
                    n_rcpt  = i_receipt_in;
                    n_res   = '0;
                    n_freq  = '0;
                    n_addr  = '0;
                    o_raddr = '0;
                    n_state = S_DONE;
                    case (i_opcode)
                        OP_PUT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else if (r_count >= r_hw) begin
                                // fresh slot: its receipt is its own index
                                o_waddr             = cnt_addr;
                                o_val_we            = 1'b1;
                                o_val_wdata         = DATA_W'(i_item_value);
                                o_hdl_we            = 1'b1;
                                o_hdl_wdata         = cnt_addr;
                                n_res.receipt_out   = RCPT_W'(cnt_addr);
                                n_hw                = r_hw + CW'(1);
                                n_count             = r_count + CW'(1);
                            end else begin
                                // reused slot: fetch its parked receipt
                                o_raddr = cnt_addr;
                                n_state = S_PUTRD;
                            end
                        end
                        OP_TAKE, OP_CONT, OP_FREQ: begin
                            if (r_count == '0) begin
                                if (i_opcode == OP_TAKE) begin
                                    n_res.status = ST_NOTFOUND;
                                end
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_PUTRD: begin
                o_waddr           = cnt_addr;
                o_val_we          = 1'b1;
                o_val_wdata       = r_val;
                n_res.receipt_out = RCPT_W'(i_hdl_rdata);
                n_count           = r_count + CW'(1);
                n_state           = S_DONE;
            end

            // one live entry compared per cycle
            S_SCAN: begin
                if (r_op == OP_TAKE) begin
                    if (hdl_match) begin
                        n_hit          = r_addr;
                        n_res.item_out = ITEM_W'(i_val_rdata);
                        o_raddr        = last_addr;
                        n_state        = S_TKLAST;
                    end else if (is_last) begin
                        n_res.status = ST_NOTFOUND;
                        n_state      = S_DONE;
                    end else begin
                        n_addr  = r_addr + HW'(1);
                        o_raddr = n_addr;
                    end
                end else begin
                    if (is_last) begin
                        if (r_op == OP_CONT) begin
                            n_res.found = (freq_nxt != '0);
                        end else begin
                            n_res.frequency = FREQ_W'(freq_nxt);
                        end
                        n_state = S_DONE;
                    end else begin
                        n_freq  = freq_nxt;
                        n_addr  = r_addr + HW'(1);
                        o_raddr = n_addr;
                    end
                end
            end

            // move last entry into the hole
            S_TKLAST: begin
                o_waddr     = r_hit;
                o_val_we    = 1'b1;
                o_val_wdata = i_val_rdata;
                o_hdl_we    = 1'b1;
                o_hdl_wdata = i_hdl_rdata;
                n_state     = S_TKFREE;
            end

            // park the freed receipt just past the new end
            S_TKFREE: begin
                o_waddr     = last_addr;
                o_hdl_we    = 1'b1;
                o_hdl_wdata = HW'(r_rcpt);
                n_count     = cnt_m1;
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hw    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hw    <= n_hw;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_val  <= n_val;
        r_rcpt <= n_rcpt;
        r_addr <= n_addr;
        r_hit  <= n_hit;
        r_freq <= n_freq;
        r_res  <= n_res;
    end

    // Result with the table occupancy after the operation
    always_comb begin
        o_res           = r_res;
        o_res.size      = SIZE_W'(r_count);
        o_res.empty_res = (r_count == '0);
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: hw/rtl/receipt_handle_table_top.sv
// Receipt handle table top level: memories, sequencer and output register.
//
//  channel | direction | handshake                  | fields
//  --------+-----------+----------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_opcode i_item_value i_receipt_in
//  out     | output    | o_out_valid / i_out_stall  | o_status o_receipt_out o_item_out
//          |           |                            | o_found o_frequency o_size o_empty_res
//
// Put and clear finish directly; put into a reused slot first reads its parked receipt.
// Contains, count value and take out scan the live entries: the scan reads
// one entry per cycle through the shared memory read address, then the swap needs two writes.
// Reset (synchronous, active low) empties the table; no clearing pass is run.
// A finished item waits in the output register while the next item is accepted;
// the sequencer holds its result only when that register is full and stalled.
module receipt_handle_table_top #(
    parameter int CAPACITY = 16,
    parameter int DATA_W   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rht_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [rht_pkg::ITEM_W-1:0]    i_item_value,
    input  logic [rht_pkg::RCPT_W-1:0]    i_receipt_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rht_pkg::STATUS_W-1:0]  o_status,
    output logic [rht_pkg::RCPT_W-1:0]    o_receipt_out,
    output logic [rht_pkg::ITEM_W-1:0]    o_item_out,
    output logic                          o_found,
    output logic [rht_pkg::FREQ_W-1:0]    o_frequency,
    output logic [rht_pkg::SIZE_W-1:0]    o_size,
    output logic                          o_empty_res
);

    import rht_pkg::*;

    localparam int HW = $clog2(CAPACITY);

    logic [HW-1:0]     raddr;
    logic [HW-1:0]     waddr;
    logic              val_we;
    logic [DATA_W-1:0] val_wdata;
    logic [DATA_W-1:0] val_rdata;
    logic              hdl_we;
    logic [HW-1:0]     hdl_wdata;
    logic [HW-1:0]     hdl_rdata;
    logic              out_free;
    logic              res_valid;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;

    // Stored values
    rht_mem #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_val_mem (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    // Receipts held by each slot
    rht_mem #(
        .WIDTH (HW),
        .DEPTH (CAPACITY)
    ) u_hdl_mem (
        .i_clk   (i_clk),
        .i_we    (hdl_we),
        .i_waddr (waddr),
        .i_wdata (hdl_wdata),
        .i_raddr (raddr),
        .o_rdata (hdl_rdata)
    );

    rht_ctrl #(
        .CAPACITY (CAPACITY),
        .DATA_W   (DATA_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_item_value (i_item_value),
        .i_receipt_in (i_receipt_in),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_raddr      (raddr),
        .o_waddr      (waddr),
        .o_val_we     (val_we),
        .o_val_wdata  (val_wdata),
        .i_val_rdata  (val_rdata),
        .o_hdl_we     (hdl_we),
        .o_hdl_wdata  (hdl_wdata),
        .i_hdl_rdata  (hdl_rdata)
    );

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_receipt_out = r_out.receipt_out;
    assign o_item_out    = r_out.item_out;
    assign o_found       = r_out.found;
    assign o_frequency   = r_out.frequency;
    assign o_size        = r_out.size;
    assign o_empty_res   = r_out.empty_res;

endmodule
